@@ rtl/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the command path record and replay block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // input word opcodes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DRIVE      = 3'd1,
    OP_REC_START  = 3'd2,
    OP_REC_STOP   = 3'd3,
    OP_PLAY_START = 3'd4,
    OP_PLAY_STOP  = 3'd5
  } op_e;

  // message codes reported with each result word
  typedef enum logic [2:0] {
    MSG_NONE      = 3'd0,
    MSG_REC_START = 3'd1,
    MSG_EMPTY     = 3'd2,
    MSG_REC_DONE  = 3'd3,
    MSG_PLAYING   = 3'd4,
    MSG_STOPPED   = 3'd5
  } msg_e;

  // operating mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic {
    S_ACCEPT = 1'b0,
    S_EXEC   = 1'b1
  } state_e;

  localparam logic [7:0]  HELD_CMD_RESET = 8'd83;  // 'S', the stop command
  localparam logic [15:0] MIN_HOLD_RESET = 16'd30;

endpackage

@@ rtl/command_path_record_replay.sv @@
// ----------------------------------------------------------------------------
// command_path_record_replay
// Records drive commands with their hold times in a step table and replays
// them on request, paced by millisecond tick words.
// ----------------------------------------------------------------------------
// Each input word passes through two states. In S_ACCEPT, as the word is
// accepted, the step table is read (at entry 0 for start play, otherwise at
// the entry after the current playback position) into a register; in S_EXEC
// the table data is used, the state is updated, any closed hold is written
// back and the result word is loaded into the output register. S_EXEC waits
// while the output register still holds an untaken result. The step table is
// one synchronous memory with a registered read; reads and writes fall in
// different states of a word, so no two accesses to one entry overlap.
// Table entries need no clearing after reset.
module command_path_record_replay #(
  parameter int STEP_DEPTH = 64,
  parameter int TIME_BITS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  cmd_byte_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drive_valid_o,
  output logic [7:0]  drive_cmd_o,
  output logic        motor_stop_o,
  output logic [2:0]  message_o,
  output logic [1:0]  mode_o
);
  import cpr_pkg::*;

  localparam int CNT_W   = $clog2(STEP_DEPTH + 1);
  localparam int IDX_W   = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam int ENTRY_W = 8 + TIME_BITS;
  localparam int CMP_W   = (TIME_BITS > 16) ? TIME_BITS : 16;

  // control and state registers
  state_e               st_q, st_d;
  mode_e                run_mode_q, run_mode_d;
  logic [CNT_W-1:0]     step_count_q, step_count_d;
  logic [CNT_W-1:0]     play_pos_q, play_pos_d;
  logic [7:0]           held_cmd_q, held_cmd_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] cur_time_q, cur_time_d;
  logic [15:0]          min_hold_q;
  op_e                  op_q;
  logic [7:0]           cmd_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 drive_valid_q, drive_valid_d;
  logic [7:0]           drive_cmd_q, drive_cmd_d;
  logic                 motor_stop_q, motor_stop_d;
  msg_e                 message_q, message_d;
  mode_e                mode_q, mode_d;

  // step table
  logic [ENTRY_W-1:0]   step_mem [STEP_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     next_pos;
  logic                 mem_we;
  logic                 accept;
  logic                 commit;
  logic                 hold_ok;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic [7:0]           rd_cmd;
  logic [TIME_BITS-1:0] rd_time;

  assign accept  = in_valid_i & in_ready_o;
  assign commit  = (st_q == S_EXEC) & (~out_valid_q | out_ready_i);
  assign next_pos = play_pos_q + CNT_W'(1);
  assign rd_cmd  = rd_data_q[ENTRY_W-1 -: 8];
  assign rd_time = rd_data_q[TIME_BITS-1:0];

  // read address: entry 0 for start play, else the entry after the current one
  always_comb begin
    rd_addr = '0;
    if (op_e'(opcode_i) != OP_PLAY_START && next_pos < CNT_W'(STEP_DEPTH)) begin
      rd_addr = next_pos[IDX_W-1:0];
    end
  end

  // saturating millisecond timer
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_BITS'(1);

  // a closed hold is stored when long enough and the table has room
  assign hold_ok = (CMP_W'(elapsed_q) > CMP_W'(min_hold_q)) &&
                   (step_count_q < CNT_W'(STEP_DEPTH));

  // step table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      step_mem[step_count_q[IDX_W-1:0]] <= {held_cmd_q, elapsed_q};
    end
    if (accept) begin
      rd_data_q <= step_mem[rd_addr];
    end
  end

  // accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      cmd_q <= cmd_byte_i;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hold_q <= MIN_HOLD_RESET;
    end else if (cfg_we_i) begin
      min_hold_q <= cfg_wdata_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_ACCEPT;
      run_mode_q   <= MODE_IDLE;
      step_count_q <= '0;
      play_pos_q   <= '0;
      held_cmd_q   <= HELD_CMD_RESET;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      run_mode_q   <= run_mode_d;
      step_count_q <= step_count_d;
      play_pos_q   <= play_pos_d;
      held_cmd_q   <= held_cmd_d;
      elapsed_q    <= elapsed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_time_q    <= cur_time_d;
    drive_valid_q <= drive_valid_d;
    drive_cmd_q   <= drive_cmd_d;
    motor_stop_q  <= motor_stop_d;
    message_q     <= message_d;
    mode_q        <= mode_d;
  end

  // sequencer: next state, state update and result word
  always_comb begin
    st_d          = st_q;
    run_mode_d    = run_mode_q;
    step_count_d  = step_count_q;
    play_pos_d    = play_pos_q;
    held_cmd_d    = held_cmd_q;
    elapsed_d     = elapsed_q;
    cur_time_d    = cur_time_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    drive_valid_d = drive_valid_q;
    drive_cmd_d   = drive_cmd_q;
    motor_stop_d  = motor_stop_q;
    message_d     = message_q;
    mode_d        = mode_q;
    mem_we        = 1'b0;
    in_ready_o    = 1'b0;

    case (st_q)
      S_ACCEPT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          st_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          st_d          = S_ACCEPT;
          out_valid_d   = 1'b1;
          drive_valid_d = 1'b0;
          drive_cmd_d   = '0;
          motor_stop_d  = 1'b0;
          message_d     = MSG_NONE;
          case (op_q)
            OP_TICK: begin
              elapsed_d = elapsed_inc;
              if (run_mode_q == MODE_PLAY && elapsed_inc >= cur_time_q) begin
                play_pos_d = next_pos;
                if (next_pos >= step_count_q) begin
                  run_mode_d   = MODE_IDLE;
                  motor_stop_d = 1'b1;
                  message_d    = MSG_STOPPED;
                end else begin
                  elapsed_d     = '0;
                  drive_valid_d = 1'b1;
                  drive_cmd_d   = rd_cmd;
                  cur_time_d    = rd_time;
                end
              end
            end
            OP_DRIVE: begin
              if (run_mode_q == MODE_REC) begin
                if (hold_ok) begin
                  mem_we       = 1'b1;
                  step_count_d = step_count_q + CNT_W'(1);
                end
                held_cmd_d = cmd_q;
                elapsed_d  = '0;
              end
            end
            OP_REC_START: begin
              step_count_d = '0;
              held_cmd_d   = HELD_CMD_RESET;
              elapsed_d    = '0;
              run_mode_d   = MODE_REC;
              message_d    = MSG_REC_START;
            end
            OP_REC_STOP: begin
              if (run_mode_q == MODE_REC) begin
                if (hold_ok) begin
                  mem_we       = 1'b1;
                  step_count_d = step_count_q + CNT_W'(1);
                end
                motor_stop_d = 1'b1;
                run_mode_d   = MODE_IDLE;
                message_d    = (step_count_d == '0) ? MSG_EMPTY : MSG_REC_DONE;
              end
            end
            OP_PLAY_START: begin
              if (step_count_q == '0) begin
                message_d = MSG_EMPTY;
              end else begin
                play_pos_d    = '0;
                elapsed_d     = '0;
                run_mode_d    = MODE_PLAY;
                message_d     = MSG_PLAYING;
                drive_valid_d = 1'b1;
                drive_cmd_d   = rd_cmd;
                cur_time_d    = rd_time;
              end
            end
            OP_PLAY_STOP: begin
              run_mode_d   = MODE_IDLE;
              motor_stop_d = 1'b1;
              message_d    = MSG_STOPPED;
            end
            default: begin
            end
          endcase
          mode_d = run_mode_d;
        end
      end
      default: begin
        st_d = S_ACCEPT;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign drive_valid_o = drive_valid_q;
  assign drive_cmd_o   = drive_cmd_q;
  assign motor_stop_o  = motor_stop_q;
  assign message_o     = message_q;
  assign mode_o        = mode_q;

  // playback only runs over a non-empty table, inside the stored steps
  a_play_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_mode_q == MODE_PLAY |-> (step_count_q != '0) && (play_pos_q < step_count_q))
    else $error("playback position outside the step table");

  // an accepted word always takes the sequencer to execution in the following cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == S_EXEC)
    else $error("accepted word not taken to execution");

  // the table is only written while recording, and never beyond its depth
  a_write_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (run_mode_q == MODE_REC) && (step_count_q < CNT_W'(STEP_DEPTH)))
    else $error("step table written outside recording");

  // the step count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_count_q <= CNT_W'(STEP_DEPTH))
    else $error("step count beyond table depth");

  // a drive word and a motor stop are never reported together
  a_drive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(drive_valid_q && motor_stop_q))
    else $error("drive and stop in one result word");

endmodule

@@ tb/tb_command_path_record_replay.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_path_record_replay
// Self-checking bench for the command path recorder: words go in on a
// valid/ready channel and a shadow of the recorder state predicts every
// result word. Directed tests cover idle handling, the hold threshold, the
// restart and abandon paths, a full step table and the longest minimum hold.
// Random record and replay sessions with noise follow, under random stalls.
// ----------------------------------------------------------------------------
module tb_command_path_record_replay;
  import cpr_pkg::*;

  localparam int STEP_DEPTH = 64;
  localparam int TIME_BITS  = 24;
  localparam int RANDOM_WORDS = 1200;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_GAP = 16;
  // opcodes the block leaves without effect
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] drive_cmd;
    logic       motor_stop;
    msg_e       message;
    mode_e      mode;
  } drive_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  opcode_i;
  logic [7:0]  cmd_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        drive_valid_o;
  logic [7:0]  drive_cmd_o;
  logic        motor_stop_o;
  logic [2:0]  message_o;
  logic [1:0]  mode_o;

  // shadow of the recorder state
  mode_e                 sh_mode;
  logic [6:0]            sh_steps;
  logic [7:0]            sh_step_cmd [STEP_DEPTH];
  logic [TIME_BITS-1:0]  sh_step_ms [STEP_DEPTH];
  logic [7:0]            sh_held;
  logic [TIME_BITS-1:0]  sh_elapsed;
  logic [6:0]            sh_pos;
  logic [15:0]           sh_min_hold;

  drive_word_t drive_words_due[$];

  bit in_idle_on;
  bit out_idle_on;
  int errors;
  int words_sent;
  int words_checked;
  int steps_replayed;
  int holds_kept;
  int holds_dropped_full;
  int quiet_cycles;

  command_path_record_replay #(
    .STEP_DEPTH(STEP_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .cmd_byte_i   (cmd_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_valid_o(drive_valid_o),
    .drive_cmd_o  (drive_cmd_o),
    .motor_stop_o (motor_stop_o),
    .message_o    (message_o),
    .mode_o       (mode_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // close the held command, keep it only if long enough and room is left
  function automatic void close_hold();
    if ({8'd0, sh_elapsed} > {16'd0, sh_min_hold}) begin
      if (sh_steps < STEP_DEPTH) begin
        sh_step_cmd[sh_steps[5:0]] = sh_held;
        sh_step_ms[sh_steps[5:0]] = sh_elapsed;
        sh_steps = sh_steps + 7'd1;
        holds_kept++;
      end else begin
        holds_dropped_full++;
      end
    end
  endfunction

  // advance the shadow by one input word and return the result word it gives
  function automatic drive_word_t next_drive_word(input logic [2:0] op,
                                                  input logic [7:0] cmd);
    drive_word_t w;
    w = '{drive_valid: 1'b0, drive_cmd: 8'd0, motor_stop: 1'b0,
          message: MSG_NONE, mode: MODE_IDLE};
    case (op)
      OP_TICK: begin
        if (sh_elapsed != '1) sh_elapsed = sh_elapsed + 1'b1;
        if (sh_mode == MODE_PLAY && sh_elapsed >= sh_step_ms[sh_pos[5:0]]) begin
          sh_pos = sh_pos + 7'd1;
          if (sh_pos >= sh_steps) begin
            sh_mode = MODE_IDLE;
            w.motor_stop = 1'b1;
            w.message = MSG_STOPPED;
          end else begin
            sh_elapsed = '0;
            w.drive_valid = 1'b1;
            w.drive_cmd = sh_step_cmd[sh_pos[5:0]];
          end
        end
      end
      OP_DRIVE: begin
        if (sh_mode == MODE_REC) begin
          close_hold();
          sh_held = cmd;
          sh_elapsed = '0;
        end
      end
      OP_REC_START: begin
        sh_steps = '0;
        sh_held = HELD_CMD_RESET;
        sh_elapsed = '0;
        sh_mode = MODE_REC;
        w.message = MSG_REC_START;
      end
      OP_REC_STOP: begin
        if (sh_mode == MODE_REC) begin
          close_hold();
          w.motor_stop = 1'b1;
          sh_mode = MODE_IDLE;
          w.message = (sh_steps == 0) ? MSG_EMPTY : MSG_REC_DONE;
        end
      end
      OP_PLAY_START: begin
        if (sh_steps == 0) begin
          w.message = MSG_EMPTY;
        end else begin
          sh_pos = '0;
          sh_elapsed = '0;
          sh_mode = MODE_PLAY;
          w.message = MSG_PLAYING;
          w.drive_valid = 1'b1;
          w.drive_cmd = sh_step_cmd[0];
        end
      end
      OP_PLAY_STOP: begin
        sh_mode = MODE_IDLE;
        w.motor_stop = 1'b1;
        w.message = MSG_STOPPED;
      end
      default: ;
    endcase
    w.mode = sh_mode;
    if (w.drive_valid) steps_replayed++;
    return w;
  endfunction

  // send one input word after a random gap and queue its expected result
  task automatic send_word(input logic [2:0] op, input logic [7:0] cmd);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    cmd_byte_i <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    drive_words_due.push_back(next_drive_word(op, cmd));
    words_sent++;
  endtask

  // let the block drain so that it is idle
  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_hold(input logic [15:0] value);
    drain_words();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_min_hold = value;
  endtask

  // ticks around the threshold for one held command
  task automatic hold_ticks();
    int k;
    case ($urandom_range(0, 3))
      0: k = sh_min_hold;
      1: k = sh_min_hold + 1;
      2: k = $urandom_range(0, sh_min_hold + 3);
      default: k = sh_min_hold + $urandom_range(1, 4);
    endcase
    repeat (k) send_word(OP_TICK, $urandom_range(0, 255));
  endtask

  task automatic record_session(input int n_cmds, input bit clean_stop);
    send_word(OP_REC_START, $urandom_range(0, 255));
    hold_ticks();
    for (int i = 0; i < n_cmds; i++) begin
      send_word(OP_DRIVE, $urandom_range(0, 255));
      hold_ticks();
      // odd words that leave recording alone
      if ($urandom_range(0, 11) == 0)
        send_word($urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7, $urandom_range(0, 255));
    end
    if (clean_stop) send_word(OP_REC_STOP, $urandom_range(0, 255));
  endtask

  task automatic play_session();
    int abort_at;
    int n;
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : -1;
    n = 0;
    send_word(OP_PLAY_START, $urandom_range(0, 255));
    while (sh_mode == MODE_PLAY && n != abort_at && n < 5000) begin
      send_word(OP_TICK, $urandom_range(0, 255));
      n++;
    end
    if (sh_mode == MODE_PLAY) begin
      case ($urandom_range(0, 3))
        0: send_word(OP_PLAY_STOP, $urandom_range(0, 255));
        1: send_word(OP_REC_START, $urandom_range(0, 255));
        2: send_word(OP_PLAY_START, $urandom_range(0, 255));
        default: send_word(OP_DRIVE, $urandom_range(0, 255));
      endcase
    end
  endtask

  task automatic noise_burst(input int n);
    repeat (n) send_word($urandom_range(0, 7), $urandom_range(0, 255));
  endtask

  // words that must not start anything from idle
  task automatic test_idle_words();
    send_word(OP_DRIVE, 8'hFF);
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    send_word(OP_PLAY_STOP, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_UNUSED_6, 8'hAA);
    send_word(OP_UNUSED_7, 8'h55);
  endtask

  // hold above the minimum is kept, hold equal to it is dropped
  task automatic test_hold_threshold();
    write_min_hold(16'd1);
    send_word(OP_REC_START, 8'h00);
    send_word(OP_DRIVE, 8'h46);
    repeat (2) send_word(OP_TICK, 8'h00);
    send_word(OP_DRIVE, 8'h4C);
    send_word(OP_TICK, 8'h00);
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    repeat (2) send_word(OP_TICK, 8'h00);
  endtask

  // record restart, replay restart, replay abandoned by a new recording
  task automatic test_restart_paths();
    send_word(OP_REC_START, 8'h00);
    send_word(OP_DRIVE, 8'h00);
    repeat (2) send_word(OP_TICK, 8'h00);
    send_word(OP_REC_START, 8'h00);
    send_word(OP_DRIVE, 8'h00);
    repeat (2) send_word(OP_TICK, 8'h00);
    send_word(OP_DRIVE, 8'hFF);
    repeat (2) send_word(OP_TICK, 8'hFF);
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    repeat (2) send_word(OP_TICK, 8'h00);
    send_word(OP_REC_START, 8'h00);
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
  endtask

  // more holds than table entries, then a full replay
  task automatic test_table_full();
    write_min_hold(16'd0);
    send_word(OP_REC_START, 8'h00);
    repeat (STEP_DEPTH + 3) begin
      send_word(OP_DRIVE, $urandom_range(0, 255));
      send_word(OP_TICK, 8'h00);
    end
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    while (sh_mode == MODE_PLAY) send_word(OP_TICK, 8'h00);
  endtask

  // largest minimum hold: every hold falls short and the table stays empty
  task automatic test_longest_hold();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_min_hold(16'hFFFF);
    send_word(OP_REC_START, 8'h00);
    send_word(OP_DRIVE, 8'h42);
    repeat (40) send_word(OP_TICK, 8'h00);
    send_word(OP_DRIVE, 8'h46);
    repeat (40) send_word(OP_TICK, 8'h00);
    send_word(OP_REC_STOP, 8'h00);
    send_word(OP_PLAY_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_PLAY_STOP, 8'h00);
  endtask

  // random phases of record and replay sessions with noise and broken ones
  task automatic test_random_sessions();
    int first;
    int n_cmds;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0: write_min_hold(16'd0);
        1: write_min_hold(MIN_HOLD_RESET);
        default: write_min_hold($urandom_range(1, 8));
      endcase
      repeat (3) begin
        case ($urandom_range(0, 9))
          7, 8: noise_burst($urandom_range(4, 12));
          9: begin
            record_session($urandom_range(0, 3), $urandom_range(0, 1));
            noise_burst($urandom_range(1, 6));
            if ($urandom_range(0, 1)) play_session();
          end
          default: begin
            if (sh_min_hold <= 2 && $urandom_range(0, 9) == 0)
              n_cmds = $urandom_range(STEP_DEPTH - 2, STEP_DEPTH + 6);
            else if (sh_min_hold > 8)
              n_cmds = $urandom_range(0, 2);
            else
              n_cmds = $urandom_range(0, 5);
            record_session(n_cmds, 1'b1);
            play_session();
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    drive_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_words_due.size() == 0) begin
        $display("%0t ns unexpected result word: drive %0d/%0d stop %0d msg %0d mode %0d",
                 $time, drive_valid_o, drive_cmd_o, motor_stop_o, message_o, mode_o);
        errors++;
      end else begin
        want = drive_words_due.pop_front();
        check_field("drive_valid", want.drive_valid, drive_valid_o);
        check_field("drive_cmd", want.drive_cmd, drive_cmd_o);
        check_field("motor_stop", want.motor_stop, motor_stop_o);
        check_field("message", want.message, message_o);
        check_field("mode", want.mode, mode_o);
        words_checked++;
      end
    end
  end

  // result side stalls
  initial begin : result_ready
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns stalled for %0d cycles", $time, quiet_cycles);
        $display("tb_command_path_record_replay: errors");
        $finish;
      end
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    opcode_i    = OP_TICK;
    cmd_byte_i  = 8'd0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 16'd0;
    rst_ni      = 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    steps_replayed = 0;
    holds_kept = 0;
    holds_dropped_full = 0;
    quiet_cycles = 0;
    sh_mode = MODE_IDLE;
    sh_steps = '0;
    sh_held = HELD_CMD_RESET;
    sh_elapsed = '0;
    sh_pos = '0;
    sh_min_hold = MIN_HOLD_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_words();
    test_hold_threshold();
    test_restart_paths();
    test_table_full();
    test_longest_hold();
    test_random_sessions();

    drain_words();
    repeat (10) @(posedge clk_i);
    $display("%0d words sent, %0d results checked, %0d replayed steps", words_sent,
             words_checked, steps_replayed);
    $display("%0d holds stored, %0d dropped on a full table", holds_kept,
             holds_dropped_full);
    if (errors == 0)
      $display("tb_command_path_record_replay: clean");
    else
      $display("tb_command_path_record_replay: errors");
    $finish;
  end

endmodule
